// ===== src/hfvr_pkg.sv =====
// ============================================================================
// hfvr_pkg
// Shared widths, record types, register indexes and the arctangent table of
// the heading frame velocity rotator.
// ============================================================================
package hfvr_pkg;

    // Number of rotation steps, limited by the size of the arctangent table.
    localparam int ROTATOR_STEPS = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int ROT_STEPS     = (ROTATOR_STEPS < ATAN_ENTRIES) ? ROTATOR_STEPS
                                                                  : ATAN_ENTRIES;

    localparam int FIELD_W  = 16;   // Width of every payload field.
    localparam int PHASE_W  = 32;   // Phase as a fraction of a full turn.
    localparam int VEC_W    = 33;   // Vector component, Q2.28 plus headroom.
    localparam int ANG_W    = 33;   // Residual angle, signed.
    localparam int SPEED_SH = 14;   // Speeds are scaled to Q2.28 on entry.

    // Register file.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_POSITION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_GAIN = 2'd1;
    localparam logic [FIELD_W-1:0] CENTER_POSITION_RESET = 16'd0;
    localparam logic [FIELD_W-1:0] CORRECTION_GAIN_RESET = 16'd19661;

    // Reciprocal of the rotator gain in Q1.30, rounded away with 2^43 then >> 44.
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam int OUT_SHIFT = 44;

    // One item moving through the rotator.
    typedef struct packed {
        logic signed [VEC_W-1:0] u;   // Forward component.
        logic signed [VEC_W-1:0] v;   // Sideways component.
        logic signed [ANG_W-1:0] z;   // Angle still to rotate.
    } rot_t;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    function automatic logic [PHASE_W-1:0] atan_turns(input logic [4:0] idx);
        logic [PHASE_W-1:0] t;
        begin
            case (idx)
                5'd0:    t = 32'h20000000;
                5'd1:    t = 32'h12E4051E;
                5'd2:    t = 32'h09FB385B;
                5'd3:    t = 32'h051111D4;
                5'd4:    t = 32'h028B0D43;
                5'd5:    t = 32'h0145D7E1;
                5'd6:    t = 32'h00A2F61E;
                5'd7:    t = 32'h00517C55;
                5'd8:    t = 32'h0028BE53;
                5'd9:    t = 32'h00145F2F;
                5'd10:   t = 32'h000A2F98;
                5'd11:   t = 32'h000517CC;
                5'd12:   t = 32'h00028BE6;
                5'd13:   t = 32'h000145F3;
                5'd14:   t = 32'h0000A2FA;
                5'd15:   t = 32'h0000517D;
                5'd16:   t = 32'h000028BE;
                5'd17:   t = 32'h0000145F;
                5'd18:   t = 32'h00000A30;
                5'd19:   t = 32'h00000518;
                5'd20:   t = 32'h0000028C;
                5'd21:   t = 32'h00000146;
                5'd22:   t = 32'h000000A3;
                5'd23:   t = 32'h00000051;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

// ===== src/hfvr_angle.sv =====
// ============================================================================
// hfvr_angle
// Front end: forms the rotation phase from the heading error and the gain,
// then folds it into the right half plane and scales the speeds.
// ============================================================================
module hfvr_angle (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hfvr_pkg::FIELD_W-1:0] speed_x,
    input  logic signed [hfvr_pkg::FIELD_W-1:0] speed_y,
    input  logic signed [hfvr_pkg::FIELD_W-1:0] heading_position,
    input  logic signed [hfvr_pkg::FIELD_W-1:0] center_position,
    input  logic        [hfvr_pkg::FIELD_W-1:0] correction_gain,
    output logic                                out_valid,
    input  logic                                out_ready,
    output hfvr_pkg::rot_t                      out_data
);

    // Stage A: phase product.
    logic                                a_valid_reg;
    logic [hfvr_pkg::PHASE_W-1:0]        phase_reg;
    logic [hfvr_pkg::PHASE_W-1:0]        phase_next;
    logic signed [hfvr_pkg::FIELD_W-1:0] sx_reg;
    logic signed [hfvr_pkg::FIELD_W-1:0] sy_reg;
    logic signed [hfvr_pkg::FIELD_W:0]   diff;
    logic signed [2*hfvr_pkg::FIELD_W+1:0] prod;
    logic                                a_ready;

    // Stage B: quadrant fold.
    logic                                b_valid_reg;
    hfvr_pkg::rot_t                      b_reg;
    hfvr_pkg::rot_t                      b_next;
    logic                                b_ready;
    logic                                fold;
    logic signed [hfvr_pkg::VEC_W-1:0]   u_base;
    logic signed [hfvr_pkg::VEC_W-1:0]   v_base;
    logic signed [hfvr_pkg::PHASE_W-1:0] z_fold;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // The phase is the product times four, kept modulo a full turn.
    always_comb
    begin
        diff       = 17'(center_position) - 17'(heading_position);
        prod       = 34'(diff) * $signed({18'd0, correction_gain});
        phase_next = {prod[hfvr_pkg::PHASE_W-3:0], 2'b00};
    end

    // Angles in the left half plane are turned by a half turn and the vector
    // is negated, which leaves the residual angle within a quarter turn.
    always_comb
    begin
        fold     = phase_reg[hfvr_pkg::PHASE_W-1] ^ phase_reg[hfvr_pkg::PHASE_W-2];
        u_base   = hfvr_pkg::VEC_W'(sy_reg) <<< hfvr_pkg::SPEED_SH;
        v_base   = hfvr_pkg::VEC_W'(sx_reg) <<< hfvr_pkg::SPEED_SH;
        z_fold   = {phase_reg[hfvr_pkg::PHASE_W-1] ^ fold,
                    phase_reg[hfvr_pkg::PHASE_W-2:0]};
        b_next.u = fold ? -u_base : u_base;
        b_next.v = fold ? -v_base : v_base;
        b_next.z = hfvr_pkg::ANG_W'(z_fold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            phase_reg <= phase_next;
            sx_reg    <= speed_x;
            sy_reg    <= speed_y;
        end
        if (a_valid_reg && b_ready)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    // After the fold the residual angle lies within a quarter turn either way.
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_reg.z[hfvr_pkg::ANG_W-1] == b_reg.z[hfvr_pkg::ANG_W-2])
                     && (b_reg.z[hfvr_pkg::ANG_W-2] == b_reg.z[hfvr_pkg::ANG_W-3]))
        else $error("folded angle outside a quarter turn");

endmodule

// ===== src/hfvr_rotator.sv =====
// ============================================================================
// hfvr_rotator
// Pipelined vector rotator: one shift-add micro-rotation per register stage.
// ============================================================================
module hfvr_rotator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hfvr_pkg::rot_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hfvr_pkg::rot_t out_data
);

    localparam int N = hfvr_pkg::ROT_STEPS;

    hfvr_pkg::rot_t st_reg [N];
    logic [N-1:0]   vld_reg;
    logic [N-1:0]   rdy;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            hfvr_pkg::rot_t                    prev;
            hfvr_pkg::rot_t                    st_next;
            logic                              prev_valid;
            logic                              next_ready;
            logic signed [hfvr_pkg::VEC_W-1:0] pu;
            logic signed [hfvr_pkg::VEC_W-1:0] pv;
            logic signed [hfvr_pkg::VEC_W-1:0] du;
            logic signed [hfvr_pkg::VEC_W-1:0] dv;
            logic signed [hfvr_pkg::ANG_W-1:0] pz;
            logic signed [hfvr_pkg::ANG_W-1:0] step_angle;

            if (k == 0)
            begin : g_first
                assign prev       = in_data;
                assign prev_valid = in_valid;
            end
            else
            begin : g_rest
                assign prev       = st_reg[k-1];
                assign prev_valid = vld_reg[k-1];
            end

            if (k == N - 1)
            begin : g_last
                assign next_ready = out_ready;
            end
            else
            begin : g_mid
                assign next_ready = rdy[k+1];
            end

            assign rdy[k] = !vld_reg[k] || next_ready;

            // Rotate toward zero residual angle; both lines use the old vector.
            always_comb
            begin
                pu         = prev.u;
                pv         = prev.v;
                pz         = prev.z;
                du         = pv >>> k;
                dv         = pu >>> k;
                step_angle = $signed({1'b0, hfvr_pkg::atan_turns(5'(k))});
                if (!pz[hfvr_pkg::ANG_W-1])
                begin
                    st_next.u = pu - du;
                    st_next.v = pv + dv;
                    st_next.z = pz - step_angle;
                end
                else
                begin
                    st_next.u = pu + du;
                    st_next.v = pv - dv;
                    st_next.z = pz + step_angle;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    vld_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (prev_valid && rdy[k])
                begin
                    st_reg[k] <= st_next;
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

    // The rotated vector never reaches the top bit of its register.
    a_u_headroom: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N-1] |-> st_reg[N-1].u[hfvr_pkg::VEC_W-1] == st_reg[N-1].u[hfvr_pkg::VEC_W-2])
        else $error("rotator forward component overflowed its headroom");

    a_v_headroom: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N-1] |-> st_reg[N-1].v[hfvr_pkg::VEC_W-1] == st_reg[N-1].v[hfvr_pkg::VEC_W-2])
        else $error("rotator sideways component overflowed its headroom");

    // A stalled last stage keeps its item.
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[N-1] && !out_ready |=> vld_reg[N-1] && $stable(st_reg[N-1]))
        else $error("rotator dropped or changed a stalled item");

endmodule

// ===== src/hfvr_scale.sv =====
// ============================================================================
// hfvr_scale
// Back end: removes the rotator gain, rounds to Q2.14 and saturates.
// ============================================================================
module hfvr_scale (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  hfvr_pkg::rot_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [hfvr_pkg::FIELD_W-1:0]  rotated_x,
    output logic signed [hfvr_pkg::FIELD_W-1:0]  rotated_y
);

    localparam int PW = hfvr_pkg::VEC_W + 32;
    localparam int RW = PW - hfvr_pkg::OUT_SHIFT;

    logic                   m_valid_reg;
    logic signed [PW-1:0]   px_reg;
    logic signed [PW-1:0]   py_reg;
    logic signed [PW-1:0]   px_next;
    logic signed [PW-1:0]   py_next;
    logic                   m_ready;

    logic                   o_valid_reg;
    logic signed [hfvr_pkg::FIELD_W-1:0] rx_reg;
    logic signed [hfvr_pkg::FIELD_W-1:0] ry_reg;
    logic signed [hfvr_pkg::FIELD_W-1:0] rx_next;
    logic signed [hfvr_pkg::FIELD_W-1:0] ry_next;
    logic                   o_ready;

    function automatic logic signed [hfvr_pkg::FIELD_W-1:0] round_sat(
        input logic signed [PW-1:0] p);
        logic signed [PW:0]   s;
        logic signed [RW:0]   r;
        logic signed [hfvr_pkg::FIELD_W-1:0] q;
        begin
            s = (PW+1)'(p) + ((PW+1)'(1) <<< (hfvr_pkg::OUT_SHIFT - 1));
            r = (RW+1)'(s >>> hfvr_pkg::OUT_SHIFT);
            if (r > (RW+1)'(32767))
            begin
                q = 16'sh7FFF;
            end
            else if (r < -(RW+1)'(32768))
            begin
                q = 16'sh8000;
            end
            else
            begin
                q = r[hfvr_pkg::FIELD_W-1:0];
            end
            return q;
        end
    endfunction

    assign o_ready  = !o_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign in_ready = m_ready;

    always_comb
    begin
        px_next = PW'(in_data.v) * PW'(hfvr_pkg::INV_GAIN_Q30);
        py_next = PW'(in_data.u) * PW'(hfvr_pkg::INV_GAIN_Q30);
        rx_next = round_sat(px_reg);
        ry_next = round_sat(py_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= in_valid;
            end
            if (o_ready)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && m_ready)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (m_valid_reg && o_ready)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign rotated_x = rx_reg;
    assign rotated_y = ry_reg;

    // A result appears only after an item sat in the multiply stage.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(m_valid_reg))
        else $error("result appeared without a scaled item behind it");

endmodule

// ===== src/heading_frame_velocity_rotator_unit.sv =====
// ============================================================================
// heading_frame_velocity_rotator_unit
// Path: an accepted item passes 2 front-end stages, 16 rotation stages and
// 2 scaling stages before its result is valid.
// Throughput: one item per cycle while no stage stalls; every stage has its
// own valid bit and takes a new item whenever it is empty or its item moves on.
// Reset: all valid bits clear, center_position returns to 0 and
// correction_gain to 19661 (1.2 in Q2.14); payload registers are not reset.
// ============================================================================
module heading_frame_velocity_rotator_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input item channel.
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [hfvr_pkg::FIELD_W-1:0]     speed_x,
    input  logic signed [hfvr_pkg::FIELD_W-1:0]     speed_y,
    input  logic signed [hfvr_pkg::FIELD_W-1:0]     heading_position,
    // Result item channel.
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [hfvr_pkg::FIELD_W-1:0]     rotated_x,
    output logic signed [hfvr_pkg::FIELD_W-1:0]     rotated_y,
    // Register write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [hfvr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [hfvr_pkg::FIELD_W-1:0]     cfg_data
);

    // The two configuration registers. Writes to an index past the list are
    // accepted and dropped. The user must let writes land only while the pipeline
    // is idle (unenforced by the block); the front end reads the registers directly.
    logic [hfvr_pkg::FIELD_W-1:0] center_position_reg;
    logic [hfvr_pkg::FIELD_W-1:0] correction_gain_reg;

    // Links between the front end, the rotator and the scaler.
    logic           ang_valid;
    logic           ang_ready;
    hfvr_pkg::rot_t ang_data;
    logic           rot_valid;
    logic           rot_ready;
    hfvr_pkg::rot_t rot_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_position_reg <= hfvr_pkg::CENTER_POSITION_RESET;
            correction_gain_reg <= hfvr_pkg::CORRECTION_GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hfvr_pkg::REG_CENTER_POSITION: center_position_reg <= cfg_data;
                hfvr_pkg::REG_CORRECTION_GAIN: correction_gain_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Front end: the phase is (center - heading) * gain * 4 taken modulo a
    // full turn, which is the angle times pi wrapped modulo two pi. The
    // vector is folded into the right half plane before rotation.
    hfvr_angle u_angle (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .speed_x          (speed_x),
        .speed_y          (speed_y),
        .heading_position (heading_position),
        .center_position  ($signed(center_position_reg)),
        .correction_gain  (correction_gain_reg),
        .out_valid        (ang_valid),
        .out_ready        (ang_ready),
        .out_data         (ang_data)
    );

    // One micro-rotation per stage drives the residual angle toward zero.
    hfvr_rotator u_rotator (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .in_data   (ang_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    // Gain removal, rounding and saturation. Its last stage is the output
    // register; a waiting result blocks new items once the stages behind it fill.
    hfvr_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y)
    );

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// Heading frame velocity rotator testbench
// Checks every result of the rotator against a cycle-free fixed-point
// prediction made when the input item is accepted. The run covers the reset
// register values, extreme and random register settings, ignored register
// indexes, full-scale speeds, and random idle gaps on both channels. It also
// includes one long receiver stall that backs the pipeline up into its input.
// ============================================================================
module tb;

    // Indexes that decode to no register; writes to them must change nothing.
    localparam logic [hfvr_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [hfvr_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int     STALL_CYCLES   = 300;   // Length of the forced receiver hold-off.
    localparam int     DRAIN_CYCLES   = 40;    // Quiet time after the last result.
    localparam int     WATCHDOG_LIMIT = 5000;  // Cycles without any transfer.
    localparam longint INV_GAIN_Q30   = 64'sd652032874;
    localparam longint ROUND_HALF     = 64'sh0000_0800_0000_0000;   // 2^43
    localparam int     SCALE_SHIFT    = 44;

    // One commanded velocity and the turret heading it was measured at.
    typedef struct packed {
        logic signed [hfvr_pkg::FIELD_W-1:0] sx;
        logic signed [hfvr_pkg::FIELD_W-1:0] sy;
        logic signed [hfvr_pkg::FIELD_W-1:0] hp;
    } velocity_cmd_t;

    // The velocity as the chassis must see it.
    typedef struct packed {
        logic signed [hfvr_pkg::FIELD_W-1:0] rx;
        logic signed [hfvr_pkg::FIELD_W-1:0] ry;
    } chassis_vel_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                                clk              = 1'b0;
    logic                                rst_n            = 1'b0;
    logic                                in_valid         = 1'b0;
    logic                                in_ready;
    logic signed [hfvr_pkg::FIELD_W-1:0] speed_x          = '0;
    logic signed [hfvr_pkg::FIELD_W-1:0] speed_y          = '0;
    logic signed [hfvr_pkg::FIELD_W-1:0] heading_position = '0;
    logic                                out_valid;
    logic                                out_ready        = 1'b0;
    logic signed [hfvr_pkg::FIELD_W-1:0] rotated_x;
    logic signed [hfvr_pkg::FIELD_W-1:0] rotated_y;
    logic                                cfg_valid        = 1'b0;
    logic                                cfg_ready;
    logic [hfvr_pkg::CFG_INDEX_W-1:0]    cfg_index        = '0;
    logic [hfvr_pkg::FIELD_W-1:0]        cfg_data         = '0;

    heading_frame_velocity_rotator_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .speed_x          (speed_x),
        .speed_y          (speed_y),
        .heading_position (heading_position),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .rotated_x        (rotated_x),
        .rotated_y        (rotated_y),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Testbench state.
    // ------------------------------------------------------------------------
    velocity_cmd_t cmd_backlog[$];    // Items waiting to be offered.
    chassis_vel_t  chassis_due[$];    // Results owed by the block, oldest first.

    // Our own copy of the two registers, updated on each accepted write.
    logic [hfvr_pkg::FIELD_W-1:0] center_copy = hfvr_pkg::CENTER_POSITION_RESET;
    logic [hfvr_pkg::FIELD_W-1:0] gain_copy   = hfvr_pkg::CORRECTION_GAIN_RESET;

    int unsigned cmds_queued   = 0;
    int unsigned cmds_taken    = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;
    bit          in_fire       = 1'b0;   // Input item accepted at the last rising edge.
    bit          cfg_fire      = 1'b0;   // Register write accepted at the last rising edge.
    bit          gaps_on       = 1'b0;   // Random idling on both channels.
    int unsigned hold_requests = 0;      // Raised by the stimulus to ask for a long stall.
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;
    int unsigned in_gap        = 0;
    int unsigned out_gap       = 0;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    function automatic logic [31:0] arctan_turn(input int step);
        case (step)
            0:       return 32'h20000000;
            1:       return 32'h12E4051E;
            2:       return 32'h09FB385B;
            3:       return 32'h051111D4;
            4:       return 32'h028B0D43;
            5:       return 32'h0145D7E1;
            6:       return 32'h00A2F61E;
            7:       return 32'h00517C55;
            8:       return 32'h0028BE53;
            9:       return 32'h00145F2F;
            10:      return 32'h000A2F98;
            11:      return 32'h000517CC;
            12:      return 32'h00028BE6;
            13:      return 32'h000145F3;
            14:      return 32'h0000A2FA;
            15:      return 32'h0000517D;
            16:      return 32'h000028BE;
            17:      return 32'h0000145F;
            18:      return 32'h00000A30;
            19:      return 32'h00000518;
            20:      return 32'h0000028C;
            21:      return 32'h00000146;
            22:      return 32'h000000A3;
            23:      return 32'h00000051;
            default: return 32'h0;
        endcase
    endfunction

    // Undo the rotator gain with rounding, then clamp to the 16-bit range.
    function automatic logic [hfvr_pkg::FIELD_W-1:0] scale_saturate(input longint w);
        longint r;
        r = (w * INV_GAIN_Q30 + ROUND_HALF) >>> SCALE_SHIFT;
        if (r > 32767)
            r = 32767;
        else if (r < -32768)
            r = -32768;
        return r[hfvr_pkg::FIELD_W-1:0];
    endfunction

    // Expected chassis velocity for one command under the given registers.
    function automatic chassis_vel_t rotate_to_chassis(
        input velocity_cmd_t                cmd,
        input logic [hfvr_pkg::FIELD_W-1:0] center,
        input logic [hfvr_pkg::FIELD_W-1:0] gain);
        longint        diff;
        longint        fwd;
        longint        side;
        longint        ang;
        longint        du;
        longint        dv;
        logic [31:0]   phase;
        chassis_vel_t  res;
        diff  = longint'($signed(center)) - longint'($signed(cmd.hp));
        // Phase is a fraction of a full turn; the truncation is the wrap by two pi.
        phase = 32'(diff * longint'(gain) * 4);
        fwd   = longint'($signed(cmd.sy)) * 16384;
        side  = longint'($signed(cmd.sx)) * 16384;
        // Angles in the left half plane: flip the vector and turn by half a turn.
        if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10)
        begin
            fwd   = -fwd;
            side  = -side;
            phase = phase + 32'h8000_0000;
        end
        ang = longint'($signed(phase));
        for (int i = 0; i < hfvr_pkg::ROT_STEPS; i++)
        begin
            du = side >>> i;
            dv = fwd >>> i;
            if (ang >= 0)
            begin
                fwd  = fwd - du;
                side = side + dv;
                ang  = ang - longint'(arctan_turn(i));
            end
            else
            begin
                fwd  = fwd + du;
                side = side - dv;
                ang  = ang + longint'(arctan_turn(i));
            end
        end
        res.rx = scale_saturate(side);
        res.ry = scale_saturate(fwd);
        return res;
    endfunction

    // Idle spans: mostly none or short, now and then a long one.
    function automatic int unsigned pick_idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A speed at or next to full scale, zero, or minus one.
    function automatic logic [hfvr_pkg::FIELD_W-1:0] corner_speed();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'h7FFF;
            3:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Random command: mostly uniform, some full-scale speeds, and some headings
    // close to the alignment point where the angle is near zero.
    function automatic velocity_cmd_t random_cmd();
        velocity_cmd_t c;
        int unsigned   pick;
        c.sx = hfvr_pkg::FIELD_W'($urandom);
        c.sy = hfvr_pkg::FIELD_W'($urandom);
        c.hp = hfvr_pkg::FIELD_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            c.sx = corner_speed();
            c.sy = corner_speed();
        end
        else if (pick == 2)
        begin
            c.hp = hfvr_pkg::FIELD_W'(int'(center_copy) + int'($urandom_range(0, 64)) - 32);
        end
        return c;
    endfunction

    task automatic push_cmd(input logic [hfvr_pkg::FIELD_W-1:0] sx,
                            input logic [hfvr_pkg::FIELD_W-1:0] sy,
                            input logic [hfvr_pkg::FIELD_W-1:0] hp);
        velocity_cmd_t c;
        c.sx = sx;
        c.sy = sy;
        c.hp = hp;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // Register write over the configuration channel; returns once accepted.
    task automatic write_reg(input logic [hfvr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [hfvr_pkg::FIELD_W-1:0]     val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Every item has exactly one result, so once all have come the block is idle.
    task automatic wait_drained();
        do @(negedge clk); while (cmds_taken != cmds_queued || chassis_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Acceptance and checking, all at the rising edge. The payload and the
    // valid bits were driven at the falling edge, so they are stable here, and
    // the block's outputs still hold their values from before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        velocity_cmd_t cmd;
        chassis_vel_t  want;
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            cfg_fire <= 1'b0;
        end
        else
        begin
            in_fire  <= in_valid && in_ready;
            cfg_fire <= cfg_valid && cfg_ready;

            // Writes to the spare indexes are dropped, as in the block.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == hfvr_pkg::REG_CENTER_POSITION)
                    center_copy = cfg_data;
                else if (cfg_index == hfvr_pkg::REG_CORRECTION_GAIN)
                    gain_copy = cfg_data;
            end

            // Registers only change while the pipeline is empty, so the copy
            // in use now is the one this item will be rotated with.
            if (in_valid && in_ready)
            begin
                cmd.sx = speed_x;
                cmd.sy = speed_y;
                cmd.hp = heading_position;
                chassis_due.push_back(rotate_to_chassis(cmd, center_copy, gain_copy));
                cmds_taken++;
            end

            if (out_valid && out_ready)
            begin
                if (chassis_due.size() == 0)
                begin
                    $display("%0t: result with none expected: rotated_x=%0d rotated_y=%0d",
                             $time, rotated_x, rotated_y);
                    error_count++;
                end
                else
                begin
                    want = chassis_due.pop_front();
                    if (rotated_x !== want.rx)
                    begin
                        $display("%0t: rotated_x expected %0d actual %0d",
                                 $time, $signed(want.rx), rotated_x);
                        error_count++;
                    end
                    if (rotated_y !== want.ry)
                    begin
                        $display("%0t: rotated_y expected %0d actual %0d",
                                 $time, $signed(want.ry), rotated_y);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a run that stops moving for too long is a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input driver. An offered item is held until the rising edge that takes
    // it; only then may the driver idle or move on to the next item.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : cmd_driver
        velocity_cmd_t cmd_out;
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd_out          = cmd_backlog.pop_front();
                    speed_x          <= cmd_out.sx;
                    speed_y          <= cmd_out.sy;
                    heading_position <= cmd_out.hp;
                    in_valid         <= 1'b1;
                    in_gap           = gaps_on ? pick_idle_span() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Besides random gaps it serves the long hold-off that
    // the stimulus asks for; the hold-off is counted here, not by the asker.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = STALL_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (out_gap != 0)
            begin
                out_ready <= 1'b0;
                out_gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    out_gap = pick_idle_span();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed opening under the reset registers, then phases of
    // random items, each under its own register setting.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [hfvr_pkg::FIELD_W-1:0] new_center;
        logic [hfvr_pkg::FIELD_W-1:0] new_gain;
        int unsigned                  n_items;
        bit                           phase_gaps;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    new_center = hfvr_pkg::CENTER_POSITION_RESET;
                    new_gain   = hfvr_pkg::CORRECTION_GAIN_RESET;
                    n_items    = 150;
                    phase_gaps = 1'b1;
                end
                1:
                begin
                    new_center = 16'h8000;
                    new_gain   = 16'h0000;
                    n_items    = 150;
                    phase_gaps = 1'b0;
                end
                2:
                begin
                    new_center = 16'h7FFF;
                    new_gain   = 16'hFFFF;
                    n_items    = 200;
                    phase_gaps = 1'b1;
                end
                3:
                begin
                    new_center = 16'h0000;
                    new_gain   = 16'd16384;
                    n_items    = 200;
                    phase_gaps = 1'b0;
                end
                4:
                begin
                    new_center = hfvr_pkg::FIELD_W'($urandom);
                    new_gain   = hfvr_pkg::FIELD_W'($urandom);
                    n_items    = 200;
                    phase_gaps = 1'b1;
                end
                5:
                begin
                    new_center = 16'd12345;
                    new_gain   = hfvr_pkg::CORRECTION_GAIN_RESET;
                    n_items    = 150;
                    phase_gaps = 1'b1;
                end
                6:
                begin
                    new_center = 16'hFFFF;
                    new_gain   = 16'd1;
                    n_items    = 150;
                    phase_gaps = 1'b1;
                end
                default:
                begin
                    new_center = hfvr_pkg::FIELD_W'($urandom);
                    new_gain   = hfvr_pkg::FIELD_W'($urandom);
                    n_items    = 200;
                    phase_gaps = 1'b1;
                end
            endcase

            // The first phase runs on the values the block comes out of reset with.
            if (ph != 0)
            begin
                write_reg(hfvr_pkg::REG_CENTER_POSITION, new_center);
                write_reg(hfvr_pkg::REG_CORRECTION_GAIN, new_gain);
            end
            // Writes to indexes past the last register must leave both alone.
            if (ph == 1)
                write_reg(REG_SPARE_A, hfvr_pkg::FIELD_W'($urandom));
            if (ph == 4)
                write_reg(REG_SPARE_B, hfvr_pkg::FIELD_W'($urandom));

            gaps_on = phase_gaps;

            if (ph == 0)
            begin
                // Zero angle: output equals input, zero and full-scale speeds.
                push_cmd(16'h0000, 16'h0000, 16'h0000);
                push_cmd(16'h7FFF, 16'h0000, 16'h0000);
                push_cmd(16'h0000, 16'h7FFF, 16'h0000);
                push_cmd(16'h8000, 16'h8000, 16'h0000);
                push_cmd(16'h7FFF, 16'h8000, 16'h0000);
                // Heading extremes; the gain pushes the angle past a half turn.
                push_cmd(16'd16384, 16'd16384, 16'h8000);
                push_cmd(16'd16384, 16'd16384, 16'h7FFF);
                push_cmd(16'h8001, 16'h7FFF, 16'h8000);
                // Near an eighth of a turn either way: full-scale speeds saturate.
                push_cmd(16'h7FFF, 16'h7FFF, -16'sd6827);
                push_cmd(16'h8000, 16'h8000, -16'sd6827);
                push_cmd(16'h8000, 16'h7FFF, 16'sd6827);
                push_cmd(16'h7FFF, 16'h8000, 16'sd6827);
                // Quarter and half turns, where the vector gets flipped first.
                push_cmd(16'h7FFF, 16'h8000, -16'sd13653);
                push_cmd(16'sd100, -16'sd200, 16'sd13653);
                push_cmd(16'sd100, -16'sd200, 16'sd27307);
                push_cmd(-16'sd5000, 16'sd9000, -16'sd27307);
                // One heading inside each quadrant.
                push_cmd(16'sd12000, 16'sd3000, 16'sd4096);
                push_cmd(16'sd12000, 16'sd3000, -16'sd4096);
                push_cmd(-16'sd7000, 16'sd20000, 16'sd20000);
                push_cmd(-16'sd7000, 16'sd20000, -16'sd20000);
            end

            repeat (n_items)
            begin
                cmd_backlog.push_back(random_cmd());
                cmds_queued++;
            end

            // With the sender offering back to back, a long stall at the
            // result side fills the pipeline and must hold in_ready low.
            if (ph == 3)
                hold_requests++;

            wait_drained();
        end

        // Give any stray result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
